/* rtl/ssle_pkg.sv */
package ssle_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CountW = $clog2(Capacity + 1);
  localparam int unsigned KeyW = 32;
  localparam int unsigned ActW = 3;
  localparam int unsigned StatW = 3;
  localparam int unsigned EntW = 7;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic signed [KeyW-1:0] key_t;

  typedef enum logic [ActW-1:0] {
    ActInsert  = 3'd0,
    ActDelete  = 3'd1,
    ActSearch  = 3'd2,
    ActSort    = 3'd3,
    ActReverse = 3'd4,
    ActRotate  = 3'd5,
    ActNop6    = 3'd6,
    ActNop7    = 3'd7
  } action_e;

  typedef enum logic [StatW-1:0] {
    StDone    = 3'd0,
    StDup     = 3'd1,
    StMissing = 3'd2,
    StEmpty   = 3'd3,
    StFull    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SScanRd,
    SScanChk,
    SShiftRd,
    SShiftWr,
    SSortRdI,
    SSortRdJ,
    SSortCmp,
    SSortWr,
    SRevRd,
    SRevRdB,
    SRevWr,
    SRotRd,
    SOut
  } state_e;

  typedef struct packed {
    logic we;
    addr_t waddr;
    key_t wdata;
    addr_t raddr;
  } mem_req_t;

endpackage

/* rtl/ssle_if.sv */
interface ssle_in_if;
  logic valid;
  logic ready;
  logic [ssle_pkg::ActW-1:0] action;
  logic signed [ssle_pkg::KeyW-1:0] key;
  modport source (output valid, action, key, input ready);
  modport sink (input valid, action, key, output ready);
endinterface

interface ssle_out_if;
  logic valid;
  logic ready;
  logic found;
  logic [ssle_pkg::StatW-1:0] status;
  logic [ssle_pkg::EntW-1:0] entries;
  modport source (output valid, found, status, entries, input ready);
  modport sink (input valid, found, status, entries, output ready);
endinterface

/* rtl/sorted_set_list_engine.sv */
// sorted_set_list_engine: ordered key list of up to Capacity signed keys.
// Input channel in_i carries action and key; output channel out_o returns
// found, status and entries, one word per accepted input word.
// A simple dual-port store (one write, one registered read per cycle) holds the
// keys; a sequencer walks it with one compare unit.
// Work per word: insert/delete/search scan entries and then move entries;
// reverse swaps pairs from both ends; rotate moves every entry; sort makes
// count*(count-1)/2 compares.
// in_i.ready is high only in the idle state; one word is processed at a
// time. The result holds on out_o until taken; a stalled receiver stalls
// the block. Reset empties the list (count zero); store contents are not
// cleared and need no clearing pass.
module sorted_set_list_engine (
  input logic clk_i,
  input logic rst_ni,
  ssle_in_if.sink in_i,
  ssle_out_if.source out_o
);

  ssle_pkg::mem_req_t req;
  ssle_pkg::key_t rdata;

  ssle_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .req_o   (req),
    .rdata_i (rdata)
  );

  ssle_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

endmodule

/* rtl/ssle_store.sv */
module ssle_store (
  input  logic                clk_i,
  input  ssle_pkg::mem_req_t  req_i,
  output ssle_pkg::key_t      rdata_o
);

  ssle_pkg::key_t mem_q [ssle_pkg::Capacity];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

/* rtl/ssle_ctrl.sv */
module ssle_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  ssle_in_if.sink            in_i,
  ssle_out_if.source         out_o,
  output ssle_pkg::mem_req_t req_o,
  input  ssle_pkg::key_t     rdata_i
);

  ssle_pkg::state_e state_q, state_d;
  ssle_pkg::action_e act_q, act_d;
  ssle_pkg::key_t key_q, key_d;
  ssle_pkg::key_t prev_q, prev_d;
  ssle_pkg::key_t hold_q, hold_d;
  ssle_pkg::count_t cnt_q, cnt_d;
  ssle_pkg::count_t i_q, i_d;
  ssle_pkg::count_t j_q, j_d;
  ssle_pkg::count_t pos_q, pos_d;
  ssle_pkg::status_e st_q, st_d;
  logic found_q, found_d;
  ssle_pkg::mem_req_t req;

  // i/j widened by one bit so that they can hold the count itself
  always_comb begin
    state_d = state_q;
    act_d = act_q;
    key_d = key_q;
    prev_d = prev_q;
    hold_d = hold_q;
    cnt_d = cnt_q;
    i_d = i_q;
    j_d = j_q;
    pos_d = pos_q;
    st_d = st_q;
    found_d = found_q;
    req = '0;
    req.wdata = key_q;
    in_i.ready = 1'b0;
    out_o.valid = 1'b0;
    unique case (state_q)
      ssle_pkg::SIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          act_d = ssle_pkg::action_e'(in_i.action);
          key_d = in_i.key;
          st_d = ssle_pkg::StDone;
          found_d = 1'b0;
          i_d = '0;
          state_d = ssle_pkg::SOut;
          unique case (ssle_pkg::action_e'(in_i.action))
            ssle_pkg::ActInsert: begin
              if (cnt_q == ssle_pkg::count_t'(ssle_pkg::Capacity)) begin
                st_d = ssle_pkg::StFull;
              end else if (cnt_q == '0) begin
                req.we = 1'b1;
                req.waddr = '0;
                req.wdata = in_i.key;
                cnt_d = ssle_pkg::count_t'(1);
              end else begin
                state_d = ssle_pkg::SScanRd;
              end
            end
            ssle_pkg::ActDelete, ssle_pkg::ActSearch: begin
              if (cnt_q == '0) st_d = ssle_pkg::StEmpty;
              else state_d = ssle_pkg::SScanRd;
            end
            ssle_pkg::ActSort: begin
              if (cnt_q > ssle_pkg::count_t'(1)) state_d = ssle_pkg::SSortRdI;
            end
            ssle_pkg::ActReverse: begin
              if (cnt_q > ssle_pkg::count_t'(1)) begin
                j_d = cnt_q - ssle_pkg::count_t'(1);
                state_d = ssle_pkg::SRevRd;
              end
            end
            ssle_pkg::ActRotate: begin
              if (cnt_q > ssle_pkg::count_t'(1)) begin
                i_d = cnt_q - ssle_pkg::count_t'(1);
                state_d = ssle_pkg::SRotRd;
              end
            end
            default: ;
          endcase
        end
      end
      ssle_pkg::SScanRd: begin
        req.raddr = i_q[ssle_pkg::AddrW-1:0];
        state_d = ssle_pkg::SScanChk;
      end
      ssle_pkg::SScanChk: begin
        // rdata_i is entry i; prev_q is entry i-1
        state_d = ssle_pkg::SScanRd;
        i_d = i_q + ssle_pkg::count_t'(1);
        prev_d = rdata_i;
        if (act_q == ssle_pkg::ActInsert) begin
          if (i_q != '0 && prev_q < key_q && key_q < rdata_i) begin
            pos_d = i_q;
            state_d = ssle_pkg::SShiftRd;
          end else if (rdata_i == key_q) begin
            st_d = ssle_pkg::StDup;
            state_d = ssle_pkg::SOut;
          end else if (i_q == '0 && key_q < rdata_i) begin
            pos_d = '0;
            state_d = ssle_pkg::SShiftRd;
          end else if (i_q + ssle_pkg::count_t'(1) == cnt_q) begin
            req.we = 1'b1;
            req.waddr = cnt_q[ssle_pkg::AddrW-1:0];
            cnt_d = cnt_q + ssle_pkg::count_t'(1);
            state_d = ssle_pkg::SOut;
          end
          if (state_d == ssle_pkg::SShiftRd) i_d = cnt_q;
        end else begin
          if (rdata_i == key_q) begin
            if (act_q == ssle_pkg::ActSearch) begin
              found_d = 1'b1;
              state_d = ssle_pkg::SOut;
            end else begin
              i_d = i_q + ssle_pkg::count_t'(1);
              state_d = ssle_pkg::SShiftRd;
            end
          end else if (i_q + ssle_pkg::count_t'(1) == cnt_q) begin
            st_d = ssle_pkg::StMissing;
            state_d = ssle_pkg::SOut;
          end
        end
      end
      ssle_pkg::SShiftRd: begin
        if (act_q == ssle_pkg::ActInsert) begin
          if (i_q == pos_q) begin
            req.we = 1'b1;
            req.waddr = pos_q[ssle_pkg::AddrW-1:0];
            cnt_d = cnt_q + ssle_pkg::count_t'(1);
            state_d = ssle_pkg::SOut;
          end else begin
            req.raddr = ssle_pkg::addr_t'(i_q - ssle_pkg::count_t'(1));
            state_d = ssle_pkg::SShiftWr;
          end
        end else begin
          if (i_q == cnt_q) begin
            cnt_d = cnt_q - ssle_pkg::count_t'(1);
            state_d = ssle_pkg::SOut;
          end else begin
            req.raddr = i_q[ssle_pkg::AddrW-1:0];
            state_d = ssle_pkg::SShiftWr;
          end
        end
      end
      ssle_pkg::SShiftWr: begin
        req.we = 1'b1;
        req.wdata = rdata_i;
        state_d = ssle_pkg::SShiftRd;
        if (act_q == ssle_pkg::ActInsert) begin
          req.waddr = i_q[ssle_pkg::AddrW-1:0];
          i_d = i_q - ssle_pkg::count_t'(1);
        end else begin
          req.waddr = ssle_pkg::addr_t'(i_q - ssle_pkg::count_t'(1));
          i_d = i_q + ssle_pkg::count_t'(1);
        end
      end
      ssle_pkg::SSortRdI: begin
        if (i_q + ssle_pkg::count_t'(1) >= cnt_q) begin
          state_d = ssle_pkg::SOut;
        end else begin
          req.raddr = i_q[ssle_pkg::AddrW-1:0];
          j_d = i_q + ssle_pkg::count_t'(1);
          state_d = ssle_pkg::SSortRdJ;
        end
      end
      ssle_pkg::SSortRdJ: begin
        hold_d = rdata_i;
        req.raddr = j_q[ssle_pkg::AddrW-1:0];
        state_d = ssle_pkg::SSortCmp;
      end
      ssle_pkg::SSortCmp: begin
        // hold_q is the current value at i
        if (hold_q > rdata_i) begin
          req.we = 1'b1;
          req.waddr = i_q[ssle_pkg::AddrW-1:0];
          req.wdata = rdata_i;
          prev_d = hold_q;
          hold_d = rdata_i;
          state_d = ssle_pkg::SSortWr;
        end else begin
          j_d = j_q + ssle_pkg::count_t'(1);
          if (j_q + ssle_pkg::count_t'(1) == cnt_q) begin
            i_d = i_q + ssle_pkg::count_t'(1);
            state_d = ssle_pkg::SSortRdI;
          end else begin
            req.raddr = ssle_pkg::addr_t'(j_q + ssle_pkg::count_t'(1));
            state_d = ssle_pkg::SSortCmp;
          end
        end
      end
      ssle_pkg::SSortWr: begin
        req.we = 1'b1;
        req.waddr = j_q[ssle_pkg::AddrW-1:0];
        req.wdata = prev_q;
        j_d = j_q + ssle_pkg::count_t'(1);
        if (j_q + ssle_pkg::count_t'(1) == cnt_q) begin
          i_d = i_q + ssle_pkg::count_t'(1);
          state_d = ssle_pkg::SSortRdI;
        end else begin
          req.raddr = ssle_pkg::addr_t'(j_q + ssle_pkg::count_t'(1));
          state_d = ssle_pkg::SSortCmp;
        end
      end
      ssle_pkg::SRevRd: begin
        if (i_q >= j_q) begin
          state_d = ssle_pkg::SOut;
        end else begin
          req.raddr = i_q[ssle_pkg::AddrW-1:0];
          state_d = ssle_pkg::SRevRdB;
        end
      end
      ssle_pkg::SRevRdB: begin
        hold_d = rdata_i;
        req.raddr = j_q[ssle_pkg::AddrW-1:0];
        state_d = ssle_pkg::SRevWr;
      end
      ssle_pkg::SRevWr: begin
        req.we = 1'b1;
        req.waddr = i_q[ssle_pkg::AddrW-1:0];
        req.wdata = rdata_i;
        prev_d = hold_q;
        state_d = ssle_pkg::SSortWr;
        if (act_q == ssle_pkg::ActReverse) state_d = ssle_pkg::SRotRd;
      end
      ssle_pkg::SRotRd: begin
        if (act_q == ssle_pkg::ActReverse) begin
          // second half of a reverse swap
          req.we = 1'b1;
          req.waddr = j_q[ssle_pkg::AddrW-1:0];
          req.wdata = prev_q;
          i_d = i_q + ssle_pkg::count_t'(1);
          j_d = j_q - ssle_pkg::count_t'(1);
          state_d = ssle_pkg::SRevRd;
        end else begin
          // rotate: read last into hold, then shift right like insert at 0
          req.raddr = i_q[ssle_pkg::AddrW-1:0];
          state_d = ssle_pkg::SRevRdB;
          act_d = ssle_pkg::ActInsert;
          pos_d = '0;
          cnt_d = cnt_q - ssle_pkg::count_t'(1);
          state_d = ssle_pkg::SSortRdJ;
          j_d = cnt_q;
        end
      end
      ssle_pkg::SOut: begin
        out_o.valid = 1'b1;
        if (out_o.ready) state_d = ssle_pkg::SIdle;
      end
      default: state_d = ssle_pkg::SIdle;
    endcase
    // rotate reuses the insert shift: after reading the last entry, key_q takes it
    if (state_q == ssle_pkg::SSortRdJ && j_q == cnt_q + ssle_pkg::count_t'(1)
        && act_q == ssle_pkg::ActInsert) begin
      key_d = rdata_i;
      i_d = cnt_q;
      req.raddr = '0;
      state_d = ssle_pkg::SShiftRd;
    end
  end

  assign req_o = req;
  assign out_o.found = found_q;
  assign out_o.status = st_q;
  assign out_o.entries = ssle_pkg::EntW'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssle_pkg::SIdle;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    key_q <= key_d;
    prev_q <= prev_d;
    hold_q <= hold_d;
    i_q <= i_d;
    j_q <= j_d;
    pos_q <= pos_d;
    st_q <= st_d;
    found_q <= found_d;
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ssle_pkg::count_t'(ssle_pkg::Capacity))
    else $error("count over capacity");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ssle_pkg::SIdle && !in_i.valid) |=> $stable(cnt_q))
    else $error("count moved while idle");
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.found) |-> out_o.status == ssle_pkg::StDone)
    else $error("found with error status");
`endif

endmodule

/* test/sorted_set_list_engine_tb.sv */
module sorted_set_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    ssle_pkg::action_e act;
    ssle_pkg::key_t    key;
  } op_t;

  typedef struct {
    logic                      found;
    ssle_pkg::status_e         status;
    logic [ssle_pkg::EntW-1:0] entries;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ssle_in_if  in_ch ();
  ssle_out_if out_ch ();

  sorted_set_list_engine uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  op_t            pending_ops[$];
  res_t           expected_res[$];
  ssle_pkg::key_t list_keys[$];
  int             errors = 0;
  bit             quiet = 1'b0;
  int             hold_off = 0;
  bit             flush_req = 1'b0;

  function automatic res_t apply_op(op_t o);
    res_t r;
    int   n;
    ssle_pkg::key_t t;
    bit   hit;
    r.found = 1'b0;
    r.status = ssle_pkg::StDone;
    n = list_keys.size();
    case (o.act)
      ssle_pkg::ActInsert: begin
        if (n >= ssle_pkg::Capacity) begin
          r.status = ssle_pkg::StFull;
        end else if (n == 0) begin
          list_keys.push_back(o.key);
        end else begin
          for (int i = 0; i < n; i++) begin
            if (list_keys[i] == o.key) begin
              r.status = ssle_pkg::StDup;
              break;
            end
            if (i == 0 && o.key < list_keys[0]) begin
              list_keys.insert(0, o.key);
              break;
            end
            if (i + 1 < n && list_keys[i] < o.key && o.key < list_keys[i+1]) begin
              list_keys.insert(i + 1, o.key);
              break;
            end
            if (i + 1 == n && list_keys[i] < o.key) begin
              list_keys.push_back(o.key);
              break;
            end
          end
        end
      end
      ssle_pkg::ActDelete, ssle_pkg::ActSearch: begin
        if (n == 0) begin
          r.status = ssle_pkg::StEmpty;
        end else begin
          hit = 1'b0;
          for (int i = 0; i < n; i++) begin
            if (list_keys[i] == o.key) begin
              hit = 1'b1;
              if (o.act == ssle_pkg::ActDelete) list_keys.delete(i);
              break;
            end
          end
          if (!hit) r.status = ssle_pkg::StMissing;
          else if (o.act == ssle_pkg::ActSearch) r.found = 1'b1;
        end
      end
      ssle_pkg::ActSort: begin
        for (int i = 0; i < n; i++)
          for (int j = i + 1; j < n; j++)
            if (list_keys[i] > list_keys[j]) begin
              t = list_keys[i];
              list_keys[i] = list_keys[j];
              list_keys[j] = t;
            end
      end
      ssle_pkg::ActReverse: begin
        for (int i = 0; i < n / 2; i++) begin
          t = list_keys[i];
          list_keys[i] = list_keys[n-1-i];
          list_keys[n-1-i] = t;
        end
      end
      ssle_pkg::ActRotate: begin
        if (n >= 2) begin
          t = list_keys.pop_back();
          list_keys.push_front(t);
        end
      end
      default: ;
    endcase
    r.entries = ssle_pkg::EntW'(list_keys.size());
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid  <= 1'b0;
      in_ch.action <= '0;
      in_ch.key    <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_res.push_back(apply_op('{ssle_pkg::action_e'(in_ch.action), in_ch.key}));
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (hold_off > 0) begin
          hold_off <= hold_off - 1;
          in_ch.valid <= 1'b0;
        end else if (flush_req && (expected_res.size() != 0 ||
                     (in_ch.valid && in_ch.ready))) begin
          in_ch.valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          if (flush_req) flush_req <= 1'b0;
          if (!quiet && $urandom_range(0, 5) == 0) begin
            hold_off <= $urandom_range(1, 14) - 1;
            in_ch.valid <= 1'b0;
          end else begin
            op_t o;
            o = pending_ops.pop_front();
            in_ch.valid  <= 1'b1;
            in_ch.action <= o.act;
            in_ch.key    <= o.key;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_res.size() == 0) begin
          $error("unexpected word: found=%0d status=%0d entries=%0d",
                 out_ch.found, out_ch.status, out_ch.entries);
          errors++;
        end else begin
          res_t e;
          e = expected_res.pop_front();
          if (out_ch.found !== e.found) begin
            $error("found: expected %0d actual %0d", e.found, out_ch.found);
            errors++;
          end
          if (out_ch.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_ch.status);
            errors++;
          end
          if (out_ch.entries !== e.entries) begin
            $error("entries: expected %0d actual %0d", e.entries, out_ch.entries);
            errors++;
          end
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        stall <= $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic ssle_pkg::key_t pick_key(int pool);
    case ($urandom_range(0, 9))
      0: return ssle_pkg::key_t'($urandom());
      1: return ssle_pkg::key_t'(32'h8000_0000 + $urandom_range(0, 3));
      2: return ssle_pkg::key_t'(32'h7fff_fffc + $urandom_range(0, 3));
      default: return ssle_pkg::key_t'($urandom_range(0, pool)) - ssle_pkg::key_t'(pool / 2);
    endcase
  endfunction

  function automatic ssle_pkg::action_e pick_act(int ins_weight);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_weight) return ssle_pkg::ActInsert;
    if (r < ins_weight + 15) return ssle_pkg::ActDelete;
    if (r < ins_weight + 30) return ssle_pkg::ActSearch;
    case ($urandom_range(0, 9))
      0, 1, 2: return ssle_pkg::ActSort;
      3, 4, 5: return ssle_pkg::ActReverse;
      6, 7, 8: return ssle_pkg::ActRotate;
      default: return ssle_pkg::action_e'($urandom_range(6, 7));
    endcase
  endfunction

  initial begin
    int pool;
    int wt;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    pending_ops.push_back('{ssle_pkg::ActDelete, 32'sd5});
    pending_ops.push_back('{ssle_pkg::ActSearch, 32'sd5});
    pending_ops.push_back('{ssle_pkg::ActSort, 32'sd0});
    pending_ops.push_back('{ssle_pkg::ActReverse, 32'sd0});
    pending_ops.push_back('{ssle_pkg::ActRotate, 32'sd0});
    pending_ops.push_back('{ssle_pkg::ActInsert, 32'sd10});
    pending_ops.push_back('{ssle_pkg::ActRotate, 32'sd0});
    pending_ops.push_back('{ssle_pkg::ActInsert, ssle_pkg::key_t'(32'h8000_0000)});
    pending_ops.push_back('{ssle_pkg::ActInsert, ssle_pkg::key_t'(32'h7fff_ffff)});
    pending_ops.push_back('{ssle_pkg::ActInsert, 32'sd10});
    pending_ops.push_back('{ssle_pkg::ActInsert, -32'sd1});
    pending_ops.push_back('{ssle_pkg::ActSearch, ssle_pkg::key_t'(32'h7fff_ffff)});
    pending_ops.push_back('{ssle_pkg::ActSearch, 32'sd11});
    pending_ops.push_back('{ssle_pkg::ActReverse, 32'sd0});
    pending_ops.push_back('{ssle_pkg::ActInsert, 32'sd3});
    pending_ops.push_back('{ssle_pkg::ActRotate, 32'sd0});
    pending_ops.push_back('{ssle_pkg::ActSort, 32'sd0});
    pending_ops.push_back('{ssle_pkg::ActDelete, 32'sd10});
    pending_ops.push_back('{ssle_pkg::ActDelete, 32'sd10});
    pending_ops.push_back('{ssle_pkg::ActNop6, 32'sd1});
    pending_ops.push_back('{ssle_pkg::ActNop7, -32'sd1});
    // fill to full, then overflow
    for (int i = 0; i < ssle_pkg::Capacity; i++)
      pending_ops.push_back('{ssle_pkg::ActInsert, ssle_pkg::key_t'($urandom())});
    pending_ops.push_back('{ssle_pkg::ActInsert, 32'sd12345});
    pending_ops.push_back('{ssle_pkg::ActReverse, 32'sd0});
    pending_ops.push_back('{ssle_pkg::ActSort, 32'sd0});
    for (int i = 0; i < ssle_pkg::Capacity + 2; i++)
      pending_ops.push_back('{ssle_pkg::ActDelete, ssle_pkg::key_t'($urandom())});
    while (pending_ops.size() != 0) @(posedge clk_i);
    flush_req = 1'b1;

    // random phases: growing, shrinking, mixed
    for (int ph = 0; ph < 6; ph++) begin
      pool = (ph % 2) ? 40 : 400;
      wt = (ph % 3 == 0) ? 60 : (ph % 3 == 1) ? 25 : 40;
      for (int i = 0; i < 70; i++)
        pending_ops.push_back('{pick_act(wt), pick_key(pool)});
      while (pending_ops.size() != 0) @(posedge clk_i);
    end
    quiet = 1'b1;
    for (int i = 0; i < 60; i++)
      pending_ops.push_back('{pick_act(40), pick_key(60)});
    while (pending_ops.size() != 0 || in_ch.valid) @(posedge clk_i);
    while (expected_res.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Verification failed");
    $finish;
  end
endmodule

/* sorted_set_list_engine.f */
rtl/ssle_pkg.sv
rtl/ssle_if.sv
rtl/ssle_store.sv
rtl/ssle_ctrl.sv
rtl/sorted_set_list_engine.sv
test/sorted_set_list_engine_tb.sv
